/* src/dual_ewma_path_selector_assert.svh */
// Assertion macros for the dual EWMA path selector.
// Expects clock aclk and active-low reset aresetn in the including scope.
`ifndef DUAL_EWMA_PATH_SELECTOR_ASSERT_SVH
`define DUAL_EWMA_PATH_SELECTOR_ASSERT_SVH

// same-cycle implication, checked out of reset
`define DEWMA_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("dewma assertion failed");

// next-cycle implication, checked out of reset
`define DEWMA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("dewma assertion failed");

`endif

/* src/dewma_pkg.sv */
// Shared types and constants for the dual EWMA path selector.
// No dependencies.
`timescale 1ns / 1ps

package dewma_pkg;

    localparam int AMOUNT_W      = 21;
    localparam int THR_W         = 21;
    localparam int GUARD_W       = 22;
    localparam int ALPHA_W       = 16;
    localparam int ELAPSED_W     = 23;
    localparam int CFG_ADDR_W    = 2;
    localparam int CFG_DATA_W    = 22;
    localparam int IN_DATA_W     = 24;
    localparam int IN_USER_W     = 2;
    localparam int OUT_DATA_W    = 24;
    localparam int FRAC_BITS_DEF = 8;

    localparam logic [THR_W-1:0]   THR_RST         = THR_W'(70000);
    localparam logic [GUARD_W-1:0] GUARD_RST       = GUARD_W'(1000000);
    localparam logic [ALPHA_W-1:0] ALPHA_SHORT_RST = ALPHA_W'(43713);
    localparam logic [ALPHA_W-1:0] ALPHA_LONG_RST  = ALPHA_W'(10093);

    localparam logic [CFG_ADDR_W-1:0] REG_DELAY_THR   = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_GUARD_TIME  = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_ALPHA_SHORT = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_ALPHA_LONG  = 2'd3;

    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_TICK   = 1'b1;

    typedef struct packed {
        logic                path_id;
        logic                kind;
        logic [AMOUNT_W-1:0] amount_us;
    } item_t;

    // packs as {short_avg_active, switched, guard_on, active_path}
    typedef struct packed {
        logic [AMOUNT_W-1:0] short_avg_active;
        logic                switched;
        logic                guard_on;
        logic                active_path;
    } result_t;

    typedef struct packed {
        logic [THR_W-1:0]   delay_threshold_us;
        logic [GUARD_W-1:0] guard_time_us;
        logic [ALPHA_W-1:0] alpha_short;
        logic [ALPHA_W-1:0] alpha_long;
    } cfg_t;

    typedef struct packed {
        logic current_path;
        logic guard_running;
    } status_t;

endpackage

/* src/dewma_ewma.sv */
// One EWMA update: (a*X + (65536-a)*avg + 32768) >> 16.
// Depends on dewma_pkg.
`timescale 1ns / 1ps

module dewma_ewma #(
    parameter int AVG_W = dewma_pkg::AMOUNT_W + dewma_pkg::FRAC_BITS_DEF
) (
    input  logic [AVG_W-1:0]             avg_i,
    input  logic [AVG_W-1:0]             x_i,
    input  logic [dewma_pkg::ALPHA_W-1:0] alpha_i,
    output logic [AVG_W-1:0]             avg_o
);
    import dewma_pkg::*;

    localparam int NEW_W = AVG_W + ALPHA_W;
    localparam int SUM_W = AVG_W + ALPHA_W + 1;
    localparam int ROUND = 1 << (ALPHA_W - 1);

    logic [ALPHA_W:0]   w_old;
    logic [NEW_W-1:0]   p_new;
    logic [SUM_W-1:0]   p_old;
    logic [SUM_W-1:0]   sum;

    always_comb begin
        w_old = (ALPHA_W+1)'(1 << ALPHA_W) - {1'b0, alpha_i};
        p_new = {{AVG_W{1'b0}}, alpha_i} * {{ALPHA_W{1'b0}}, x_i};
        p_old = {{AVG_W{1'b0}}, w_old} * {{(ALPHA_W+1){1'b0}}, avg_i};
        sum   = {1'b0, p_new} + p_old + SUM_W'(ROUND);
        // weighted mean of two in-range values, so the top bit is always clear
        avg_o = sum[NEW_W-1:ALPHA_W];
    end

endmodule

/* src/dewma_core.sv */
// Path state (averages, seen flags, guard timer, active path) and per-item update.
// Depends on dewma_pkg and dewma_ewma.
`timescale 1ns / 1ps

module dewma_core #(
    parameter int FRAC_BITS = dewma_pkg::FRAC_BITS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               step,
    input  dewma_pkg::item_t   item,
    input  dewma_pkg::cfg_t    cfg,
    output dewma_pkg::result_t res_next,
    output dewma_pkg::status_t status
);
    import dewma_pkg::*;

    localparam int AVG_W = AMOUNT_W + FRAC_BITS;

    logic [AVG_W-1:0]     short_avg_reg [2];
    logic [AVG_W-1:0]     long_avg_reg  [2];
    logic [AVG_W-1:0]     short_avg_next[2];
    logic [AVG_W-1:0]     long_avg_next [2];
    logic [1:0]           seen_reg, seen_next;
    logic                 cur_reg, cur_next;
    logic                 guard_reg, guard_next;
    logic [ELAPSED_W-1:0] elapsed_reg, elapsed_next;

    logic [AVG_W-1:0]     x;
    logic [AVG_W-1:0]     thr_x;
    logic [AVG_W-1:0]     short_upd, long_upd;
    logic [ELAPSED_W:0]   elapsed_sum;
    logic [ELAPSED_W-1:0] elapsed_sat;
    logic                 pid, oth, want, switched;

    assign pid = item.path_id;
    assign x   = AVG_W'(item.amount_us) << FRAC_BITS;

    dewma_ewma #(.AVG_W(AVG_W)) u_short (
        .avg_i   (short_avg_reg[pid]),
        .x_i     (x),
        .alpha_i (cfg.alpha_short),
        .avg_o   (short_upd)
    );

    dewma_ewma #(.AVG_W(AVG_W)) u_long (
        .avg_i   (long_avg_reg[pid]),
        .x_i     (x),
        .alpha_i (cfg.alpha_long),
        .avg_o   (long_upd)
    );

    always_comb begin
        short_avg_next[0] = short_avg_reg[0];
        short_avg_next[1] = short_avg_reg[1];
        long_avg_next[0]  = long_avg_reg[0];
        long_avg_next[1]  = long_avg_reg[1];
        seen_next         = seen_reg;
        cur_next          = cur_reg;
        guard_next        = guard_reg;
        elapsed_next      = elapsed_reg;
        switched          = 1'b0;

        if (item.kind == KIND_SAMPLE) begin
            if (!seen_reg[pid]) begin
                short_avg_next[pid] = x;
                long_avg_next[pid]  = x;
            end else begin
                short_avg_next[pid] = short_upd;
                long_avg_next[pid]  = long_upd;
            end
            seen_next[pid] = 1'b1;
        end

        // switch test on post-update averages; ticks leave averages alone
        oth   = ~cur_reg;
        thr_x = AVG_W'(cfg.delay_threshold_us) << FRAC_BITS;
        want  = (short_avg_next[cur_reg] > long_avg_next[cur_reg])
             && (short_avg_next[cur_reg] > thr_x)
             && (short_avg_next[oth] < short_avg_next[cur_reg]);

        elapsed_sum = {1'b0, elapsed_reg} + (ELAPSED_W+1)'(item.amount_us);
        elapsed_sat = elapsed_sum[ELAPSED_W] ? {ELAPSED_W{1'b1}}
                                             : elapsed_sum[ELAPSED_W-1:0];

        if (item.kind == KIND_SAMPLE) begin
            if (seen_next[0] && seen_next[1] && !guard_reg && want) begin
                guard_next   = 1'b1;
                elapsed_next = '0;
            end
        end else if (guard_reg) begin
            elapsed_next = elapsed_sat;
            if (elapsed_sat >= ELAPSED_W'(cfg.guard_time_us)) begin
                guard_next = 1'b0;
                if (want) begin
                    cur_next = ~cur_reg;
                    switched = 1'b1;
                end
            end
        end

        res_next.active_path      = cur_next;
        res_next.guard_on         = guard_next;
        res_next.switched         = switched;
        res_next.short_avg_active = short_avg_next[cur_next][AVG_W-1:FRAC_BITS];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            short_avg_reg[0] <= '0;
            short_avg_reg[1] <= '0;
            long_avg_reg[0]  <= '0;
            long_avg_reg[1]  <= '0;
            seen_reg         <= '0;
            cur_reg          <= 1'b0;
            guard_reg        <= 1'b0;
            elapsed_reg      <= '0;
        end else if (step) begin
            short_avg_reg[0] <= short_avg_next[0];
            short_avg_reg[1] <= short_avg_next[1];
            long_avg_reg[0]  <= long_avg_next[0];
            long_avg_reg[1]  <= long_avg_next[1];
            seen_reg         <= seen_next;
            cur_reg          <= cur_next;
            guard_reg        <= guard_next;
            elapsed_reg      <= elapsed_next;
        end
    end

    assign status.current_path  = cur_reg;
    assign status.guard_running = guard_reg;

endmodule

/* src/dual_ewma_path_selector.sv */
// Throughput: one transaction per cycle unless m_tready stalls the output; the input
// register, the EWMA multiplies and the result register form a two-stage flow with
// no stall of its own.
// Reset (aresetn low, synchronous): averages, seen flags, guard and path cleared,
// registers to their defaults, both channels empty.
// Top level: config registers, input and result registers around dewma_core.
`timescale 1ns / 1ps
`include "dual_ewma_path_selector_assert.svh"

module dual_ewma_path_selector #(
    parameter int FRAC_BITS = dewma_pkg::FRAC_BITS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_we,
    input  logic [dewma_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [dewma_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [dewma_pkg::IN_DATA_W-1:0]  s_tdata,  // [20:0] amount_us
    input  logic [dewma_pkg::IN_USER_W-1:0]  s_tuser,  // [0] kind, [1] path_id
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [0] active_path, [1] guard_on, [2] switched, [23:3] short_avg_active
    output logic [dewma_pkg::OUT_DATA_W-1:0] m_tdata
);
    import dewma_pkg::*;

    cfg_t    cfg_reg;
    item_t   item_reg;
    logic    in_valid_reg;
    result_t res_reg, res_next;
    logic    out_valid_reg;
    status_t status;
    logic    step, s_fire;

    assign step     = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || step;
    assign s_fire   = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.delay_threshold_us <= THR_RST;
            cfg_reg.guard_time_us      <= GUARD_RST;
            cfg_reg.alpha_short        <= ALPHA_SHORT_RST;
            cfg_reg.alpha_long         <= ALPHA_LONG_RST;
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_DELAY_THR:   cfg_reg.delay_threshold_us <= cfg_wdata[THR_W-1:0];
                REG_GUARD_TIME:  cfg_reg.guard_time_us      <= cfg_wdata[GUARD_W-1:0];
                REG_ALPHA_SHORT: cfg_reg.alpha_short        <= cfg_wdata[ALPHA_W-1:0];
                REG_ALPHA_LONG:  cfg_reg.alpha_long         <= cfg_wdata[ALPHA_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            item_reg.kind      <= s_tuser[0];
            item_reg.path_id   <= s_tuser[1];
            item_reg.amount_us <= s_tdata[AMOUNT_W-1:0];
        end
    end

    dewma_core #(.FRAC_BITS(FRAC_BITS)) u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .step     (step),
        .item     (item_reg),
        .cfg      (cfg_reg),
        .res_next (res_next),
        .status   (status)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (step) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            res_reg <= res_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = res_reg;

    // a flip ends the guard in the same transaction
    `DEWMA_ASSERT_NOW(a_switch_ends_guard, step && res_next.switched, !res_next.guard_on)
    // path changes exactly when switched is flagged
    `DEWMA_ASSERT_NOW(a_switch_flag_match, step,
        res_next.switched == (res_next.active_path != status.current_path))
    // no flip without a running guard
    `DEWMA_ASSERT_NOW(a_switch_needs_guard, step && !status.guard_running, !res_next.switched)
    // state only moves on a processed transaction
    `DEWMA_ASSERT_NEXT(a_state_holds, !step, $stable(status))

endmodule

/* sim/tb_dual_ewma_path_selector.sv */
// Testbench for dual_ewma_path_selector: directed and random RTT samples and ticks,
// checked against an in-bench model of the averages, guard and path choice.
// Depends on dewma_pkg and the dual_ewma_path_selector RTL.
`timescale 1ns / 1ps

module tb_dual_ewma_path_selector;
    import dewma_pkg::*;

    localparam int FRAC         = FRAC_BITS_DEF;
    localparam int AVG_W        = AMOUNT_W + FRAC;
    localparam int AMOUNT_TOP   = (1 << AMOUNT_W) - 1;
    localparam int CLK_PERIOD   = 12;
    localparam int PIPE_DRAIN   = 4;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_ITEMS = 1650;
    localparam int PHASE_ITEMS  = 150;
    localparam logic [ELAPSED_W-1:0] ELAPSED_SAT = '1;

    typedef logic [AVG_W-1:0] avg_t;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  cfg_we;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;   // [20:0] amount_us
    logic [IN_USER_W-1:0]  s_tuser;   // [0] kind, [1] path_id
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    // [0] active_path, [1] guard_on, [2] switched, [23:3] short_avg_active
    logic [OUT_DATA_W-1:0] m_tdata;

    // path selection model
    avg_t                  rtt_short[2];
    avg_t                  rtt_long[2];
    logic                  seen[2];
    logic                  active_m;
    logic                  guard_m;
    logic [ELAPSED_W-1:0]  guard_elapsed_m;
    cfg_t                  cfg_m;
    result_t               choices_due[$];

    int   error_count   = 0;
    int   cycle_count   = 0;
    int   hold_off      = 0;
    logic sender_idle   = 1'b1;
    logic receiver_idle = 1'b1;

    dual_ewma_path_selector #(
        .FRAC_BITS(FRAC)
    ) i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_wdata(cfg_wdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    function automatic avg_t ewma_update(avg_t avg, avg_t x, logic [ALPHA_W-1:0] a);
        logic [63:0] acc;
        acc = 64'(a) * 64'(x) + (64'd65536 - 64'(a)) * 64'(avg) + 64'd32768;
        return avg_t'(acc >> 16);
    endfunction

    // all three comparisons are strict
    function automatic logic switch_test();
        logic p;
        logic q;
        p = active_m;
        q = ~active_m;
        return rtt_short[p] > rtt_long[p]
            && rtt_short[p] > {cfg_m.delay_threshold_us, {FRAC{1'b0}}}
            && rtt_short[q] < rtt_short[p];
    endfunction

    function automatic void predict_path_choice(logic kind, logic pid,
                                                logic [AMOUNT_W-1:0] amt);
        avg_t               x;
        result_t            r;
        logic               flipped;
        logic [ELAPSED_W:0] sum;
        x = {amt, {FRAC{1'b0}}};
        flipped = 1'b0;
        if (kind == KIND_SAMPLE) begin
            if (!seen[pid]) begin
                rtt_short[pid] = x;
                rtt_long[pid]  = x;
                seen[pid]      = 1'b1;
            end else begin
                rtt_short[pid] = ewma_update(rtt_short[pid], x, cfg_m.alpha_short);
                rtt_long[pid]  = ewma_update(rtt_long[pid], x, cfg_m.alpha_long);
            end
            if (seen[0] && seen[1] && !guard_m && switch_test()) begin
                guard_m = 1'b1;
                guard_elapsed_m = '0;
            end
        end else if (guard_m) begin
            sum = guard_elapsed_m + amt;
            guard_elapsed_m = (sum > ELAPSED_SAT) ? ELAPSED_SAT : sum[ELAPSED_W-1:0];
            if (guard_elapsed_m >= cfg_m.guard_time_us) begin
                guard_m = 1'b0;
                if (switch_test()) begin
                    active_m = ~active_m;
                    flipped = 1'b1;
                end
            end
        end
        r.active_path      = active_m;
        r.guard_on         = guard_m;
        r.switched         = flipped;
        r.short_avg_active = rtt_short[active_m][AVG_W-1:FRAC];
        choices_due.push_back(r);
    endfunction

    function automatic void check_field(string name, logic [AMOUNT_W-1:0] want,
                                        logic [AMOUNT_W-1:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            error_count++;
        end
    endfunction

    // called at a rising edge; returns at the edge where the transaction is taken
    task automatic send_item(logic kind, logic pid, logic [AMOUNT_W-1:0] amt);
        int gap;
        gap = sender_idle ? $urandom_range(0, 5) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= IN_DATA_W'(amt);
        s_tuser  <= {pid, kind};
        do @(posedge aclk); while (!s_tready);
        predict_path_choice(kind, pid, amt);
    endtask

    task automatic drain_reports();
        s_tvalid <= 1'b0;
        while (choices_due.size() != 0) @(posedge aclk);
        repeat (PIPE_DRAIN) @(posedge aclk);
    endtask

    task automatic put_reg(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= data;
        @(posedge aclk);
    endtask

    task automatic load_settings(cfg_t c);
        drain_reports();
        put_reg(REG_DELAY_THR, CFG_DATA_W'(c.delay_threshold_us));
        put_reg(REG_GUARD_TIME, CFG_DATA_W'(c.guard_time_us));
        put_reg(REG_ALPHA_SHORT, CFG_DATA_W'(c.alpha_short));
        put_reg(REG_ALPHA_LONG, CFG_DATA_W'(c.alpha_long));
        cfg_we <= 1'b0;
        cfg_m = c;
    endtask

    function automatic cfg_t random_settings();
        cfg_t c;
        case ($urandom_range(0, 3))
            0: c.delay_threshold_us = '0;
            1: c.delay_threshold_us = '1;
            default: c.delay_threshold_us = THR_W'($urandom_range(0, 200000));
        endcase
        case ($urandom_range(0, 3))
            0: c.guard_time_us = '0;
            1: c.guard_time_us = '1;
            default: c.guard_time_us = GUARD_W'($urandom_range(0, 300000));
        endcase
        c.alpha_short = ($urandom_range(0, 4) == 0) ? '1 : ALPHA_W'($urandom());
        c.alpha_long  = ($urandom_range(0, 4) == 0) ? '0 : ALPHA_W'($urandom());
        return c;
    endfunction

    // long averages frozen so the two paths end up with identical short averages
    task automatic test_equal_averages();
        cfg_t c;
        c = '{delay_threshold_us: '0, guard_time_us: GUARD_RST,
              alpha_short: ALPHA_SHORT_RST, alpha_long: '0};
        load_settings(c);
        send_item(KIND_TICK, 1'b0, AMOUNT_W'(AMOUNT_TOP));
        send_item(KIND_SAMPLE, 1'b0, AMOUNT_W'(1000));
        send_item(KIND_SAMPLE, 1'b1, AMOUNT_W'(1000));
        send_item(KIND_SAMPLE, 1'b1, AMOUNT_W'(2000));
        send_item(KIND_SAMPLE, 1'b0, AMOUNT_W'(2000));
    endtask

    task automatic test_guard_and_switch();
        cfg_t c;
        c = '{delay_threshold_us: THR_RST, guard_time_us: GUARD_RST,
              alpha_short: ALPHA_SHORT_RST, alpha_long: ALPHA_LONG_RST};
        load_settings(c);
        send_item(KIND_SAMPLE, 1'b0, AMOUNT_W'(AMOUNT_TOP));
        send_item(KIND_SAMPLE, 1'b0, AMOUNT_W'(AMOUNT_TOP));   // guard must not restart
        send_item(KIND_TICK, 1'b1, AMOUNT_W'(600000));
        send_item(KIND_SAMPLE, 1'b1, '0);
        send_item(KIND_TICK, 1'b0, AMOUNT_W'(400000));       // expiry, path should flip
        send_item(KIND_TICK, 1'b0, '0);
        send_item(KIND_SAMPLE, 1'b0, '0);
        send_item(KIND_SAMPLE, 1'b1, AMOUNT_W'(AMOUNT_TOP));
        send_item(KIND_TICK, 1'b1, AMOUNT_W'(AMOUNT_TOP));
    endtask

    // zero guard time: the guard ends on the very next tick, even a 0 us one
    task automatic test_zero_guard();
        cfg_t c;
        c = '{delay_threshold_us: '0, guard_time_us: '0, alpha_short: '1, alpha_long: '1};
        load_settings(c);
        send_item(KIND_SAMPLE, ~active_m, '0);
        send_item(KIND_SAMPLE, active_m, AMOUNT_W'(AMOUNT_TOP));
        send_item(KIND_TICK, 1'b0, '0);
        send_item(KIND_SAMPLE, active_m, AMOUNT_W'(AMOUNT_TOP));
        send_item(KIND_TICK, 1'b1, '0);
    endtask

    task automatic test_random_traffic();
        cfg_t                c;
        logic                kind;
        logic                pid;
        logic [AMOUNT_W-1:0] amt;
        int                  thr;
        int                  g;
        int                  part;
        for (int phase = 0; phase < RANDOM_ITEMS / PHASE_ITEMS; phase++) begin
            if (phase == 0) begin
                c = '1;
            end else if (phase == 1) begin
                c = '0;
            end else begin
                c = random_settings();
            end
            load_settings(c);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (n % 40 == 0) begin
                    sender_idle   = ($urandom_range(0, 2) != 0);
                    receiver_idle = ($urandom_range(0, 2) != 0);
                end
                thr = cfg_m.delay_threshold_us;
                g   = cfg_m.guard_time_us;
                // mostly push the active path up and the other down, then let ticks expire
                case ($urandom_range(0, 9))
                    0, 1, 2, 3: begin
                        kind = KIND_SAMPLE;
                        pid  = active_m;
                        amt  = AMOUNT_W'($urandom_range(AMOUNT_TOP, thr));
                    end
                    4, 5: begin
                        kind = KIND_SAMPLE;
                        pid  = ~active_m;
                        amt  = AMOUNT_W'($urandom_range(thr / 2, 0));
                    end
                    6, 7, 8: begin
                        kind = KIND_TICK;
                        pid  = 1'($urandom_range(0, 1));
                        case ($urandom_range(0, 2))
                            0: amt = AMOUNT_W'($urandom_range(0, 1000));
                            1: begin
                                part = g / $urandom_range(1, 3);
                                amt  = AMOUNT_W'((part > AMOUNT_TOP) ? AMOUNT_TOP : part);
                            end
                            default: amt = AMOUNT_W'($urandom());
                        endcase
                    end
                    default: begin
                        kind = 1'($urandom_range(0, 1));
                        pid  = 1'($urandom_range(0, 1));
                        amt  = AMOUNT_W'($urandom());
                    end
                endcase
                send_item(kind, pid, amt);
            end
        end
    endtask

    // result checker and receiver stalls
    always @(posedge aclk) begin
        result_t got;
        result_t want;
        int      stall;
        if (!aresetn) begin
            m_tready <= 1'b1;
            hold_off <= 0;
        end else if (m_tvalid && m_tready) begin
            got = m_tdata;
            if (choices_due.size() == 0) begin
                $display("%0t: unexpected transaction, expected none, actual %h", $time, got);
                error_count++;
            end else begin
                want = choices_due.pop_front();
                check_field("active_path", AMOUNT_W'(want.active_path),
                            AMOUNT_W'(got.active_path));
                check_field("guard_on", AMOUNT_W'(want.guard_on), AMOUNT_W'(got.guard_on));
                check_field("switched", AMOUNT_W'(want.switched), AMOUNT_W'(got.switched));
                check_field("short_avg_active", want.short_avg_active, got.short_avg_active);
            end
            stall = receiver_idle ? $urandom_range(0, 5) : 0;
            if (stall > 0) begin
                m_tready <= 1'b0;
                hold_off <= stall;
            end
        end else if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            if (hold_off == 1) begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        aresetn   <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_addr  <= '0;
        cfg_wdata <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= '0;
        rtt_short = '{default: '0};
        rtt_long  = '{default: '0};
        seen      = '{default: 1'b0};
        active_m  = 1'b0;
        guard_m   = 1'b0;
        guard_elapsed_m = '0;
        cfg_m = '{delay_threshold_us: THR_RST, guard_time_us: GUARD_RST,
                  alpha_short: ALPHA_SHORT_RST, alpha_long: ALPHA_LONG_RST};
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_equal_averages();
        test_guard_and_switch();
        test_zero_guard();
        test_random_traffic();
        drain_reports();
        if (error_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

/* sim.f */
+incdir+src
src/dewma_pkg.sv
src/dewma_ewma.sv
src/dewma_core.sv
src/dual_ewma_path_selector.sv
sim/tb_dual_ewma_path_selector.sv
